// ===== rtl/hst_pkg.sv =====
// Shared types, sizes and codes for the handle slot table.
// No dependencies; every other file in rtl/ uses this package.
package hst_pkg;

  localparam int DEPTH   = 64;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  localparam int KIND_W  = 3;
  localparam int VALUE_W = 32;
  localparam int INDEX_W = 8;
  localparam int SLOT_W  = 7;
  localparam int FLOOR_W = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD       = 3'd0,
    KIND_SET       = 3'd1,
    KIND_CLEAR     = 3'd2,
    KIND_QUERY     = 3'd3,
    KIND_CLEAR_ALL = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_BEYOND  = 2'd2,
    ST_IGNORED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MIR_NONE   = 2'd0,
    MIR_STDIN  = 2'd1,
    MIR_STDOUT = 2'd2,
    MIR_STDERR = 2'd3
  } mirror_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              all_used;
    mirror_t           std_mirror;
    status_t           status;
  } result_t;

endpackage

// ===== rtl/hst_in_if.sv =====
// Request channel of the handle slot table: valid/ready plus one operation.
// Depends on hst_pkg for field widths.
interface hst_in_if;
  logic                             valid;
  logic                             ready;
  logic [hst_pkg::KIND_W-1:0]       kind;
  logic signed [hst_pkg::VALUE_W-1:0] value;
  logic signed [hst_pkg::INDEX_W-1:0] index;

  modport source (output valid, output kind, output value, output index, input ready);
  modport sink   (input valid, input kind, input value, input index, output ready);
endinterface

// ===== rtl/hst_out_if.sv =====
// Result channel of the handle slot table: valid/ready plus one result.
// Depends on hst_pkg for field widths and codes.
interface hst_out_if;
  logic                          valid;
  logic                          ready;
  logic [hst_pkg::SLOT_W-1:0]    slot;
  logic                          all_used;
  logic [1:0]                    std_mirror;
  logic [1:0]                    status;

  modport source (output valid, output slot, output all_used, output std_mirror,
                  output status, input ready);
  modport sink   (input valid, input slot, input all_used, input std_mirror,
                  input status, output ready);
endinterface

// ===== rtl/handle_slot_table_core.sv =====
// Handle slot table: entry memory with one write and one read port, driven by a small scan/fill sequencer.
// Depends on hst_pkg, hst_in_if and hst_out_if.
//
// Usage:
//   in_ch  carries one operation per transfer (kind, value, index).
//   out_ch returns exactly one result per operation, in order.
//   cfg_we/cfg_wdata write reserve_floor; write only while the block is idle.
// Operation timing (one operation at a time, in_ch.ready low while busy):
//   clear, clear-all, set inside the count, out-of-range cases: no scan.
//   add and query scan the entries through the single memory read port,
//   in two steps per entry (address, then compare).
//   set beyond the count zero-fills the gap one entry per cycle.
// Reset: synchronous active-low rst_n clears the count, reserve_floor and a
//   per-entry valid bit for all entries at once; an entry never written since
//   reset (or cleared) reads as zero. No clearing pass is needed.
// Receiver stall: the finished result sits in the output register; a new
//   operation is accepted while it waits, and the next result holds in the
//   sequencer until the output register frees up.
module handle_slot_table_core (
  input  logic             clk,
  input  logic             rst_n,
  hst_in_if.sink           in_ch,
  hst_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [hst_pkg::FLOOR_W-1:0] cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CK,
    S_MISS,
    S_FILL,
    S_DONE
  } state_t;

  state_t                         state_r, state_nxt;
  logic [hst_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic [hst_pkg::CNT_W-1:0]      scan_r, scan_nxt;
  hst_pkg::kind_t                 op_r, op_nxt;
  logic [hst_pkg::VALUE_W-1:0]    val_r, val_nxt;
  logic [hst_pkg::ADDR_W-1:0]     uidx_r, uidx_nxt;
  hst_pkg::result_t               pend_r, pend_nxt;
  hst_pkg::result_t               out_res_r;
  logic                           out_valid_r;
  logic [hst_pkg::FLOOR_W-1:0]    floor_r;
  logic [hst_pkg::DEPTH-1:0]      valid_r;

  // Entry memory: one write and one registered read per cycle.
  logic [hst_pkg::VALUE_W-1:0]    mem [hst_pkg::DEPTH];
  logic [hst_pkg::VALUE_W-1:0]    rdata_r;
  logic                           rvld_r;

  logic                           mem_we;
  logic [hst_pkg::ADDR_W-1:0]     mem_waddr;
  logic [hst_pkg::VALUE_W-1:0]    mem_wdata;
  logic                           vld_clr;
  logic [hst_pkg::ADDR_W-1:0]     vld_clr_addr;

  logic                           accept;
  logic                           out_free;
  logic [hst_pkg::ADDR_W-1:0]     in_uidx;
  logic                           entry_zero;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_uidx     = hst_pkg::ADDR_W'(unsigned'(in_ch.index[hst_pkg::INDEX_W-2:0]));
  // Never-written entries read as zero.
  assign entry_zero  = !rvld_r || (rdata_r == '0);

  assign out_ch.valid      = out_valid_r;
  assign out_ch.slot       = out_res_r.slot;
  assign out_ch.all_used   = out_res_r.all_used;
  assign out_ch.std_mirror = out_res_r.std_mirror;
  assign out_ch.status     = out_res_r.status;

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    scan_nxt     = scan_r;
    op_nxt       = op_r;
    val_nxt      = val_r;
    uidx_nxt     = uidx_r;
    pend_nxt     = pend_r;
    mem_we       = 1'b0;
    mem_waddr    = scan_r[hst_pkg::ADDR_W-1:0];
    mem_wdata    = val_r;
    vld_clr      = 1'b0;
    vld_clr_addr = scan_r[hst_pkg::ADDR_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt   = hst_pkg::kind_t'(in_ch.kind);
          val_nxt  = in_ch.value;
          uidx_nxt = in_uidx;
          scan_nxt = '0;
          pend_nxt = '{slot: '0, all_used: 1'b0,
                       std_mirror: hst_pkg::MIR_NONE, status: hst_pkg::ST_DONE};
          state_nxt = S_DONE;
          case (in_ch.kind)
            hst_pkg::KIND_ADD: begin
              // Scan for the lowest zero entry; an empty table appends directly.
              state_nxt = (count_r == '0) ? S_MISS : S_RD;
            end
            hst_pkg::KIND_SET: begin
              if (in_ch.index[hst_pkg::INDEX_W-1]) begin
                pend_nxt.status = hst_pkg::ST_IGNORED;
              end else if (int'(in_ch.index) >= hst_pkg::DEPTH) begin
                pend_nxt.status = hst_pkg::ST_BEYOND;
              end else begin
                pend_nxt.slot = hst_pkg::SLOT_W'(in_uidx);
                if (int'(in_ch.index) <= 2) begin
                  pend_nxt.std_mirror = hst_pkg::mirror_t'(in_ch.index[1:0] + 2'd1);
                end
                if (int'(in_ch.index) >= int'(count_r)) begin
                  // Grow: zero-fill the gap, then write.
                  scan_nxt  = count_r;
                  state_nxt = S_FILL;
                end else begin
                  mem_we    = 1'b1;
                  mem_waddr = in_uidx;
                  mem_wdata = in_ch.value;
                end
              end
            end
            hst_pkg::KIND_CLEAR: begin
              if (int'(in_ch.index) > 0 && int'(in_ch.index) < int'(count_r)) begin
                vld_clr      = 1'b1;
                vld_clr_addr = in_uidx;
              end else begin
                pend_nxt.status = hst_pkg::ST_IGNORED;
              end
            end
            hst_pkg::KIND_QUERY: begin
              if (int'(count_r) < int'(floor_r)) begin
                pend_nxt.all_used = 1'b0;
              end else if (count_r == '0) begin
                state_nxt = S_MISS;
              end else begin
                state_nxt = S_RD;
              end
            end
            hst_pkg::KIND_CLEAR_ALL: begin
              count_nxt = '0;
            end
            default: begin
              pend_nxt.status = hst_pkg::ST_IGNORED;
            end
          endcase
        end
      end

      S_RD: begin
        // Read address is scan_r; data lands next cycle.
        state_nxt = S_CK;
      end

      S_CK: begin
        if (entry_zero) begin
          if (op_r == hst_pkg::KIND_ADD) begin
            mem_we        = 1'b1;
            pend_nxt.slot = hst_pkg::SLOT_W'(scan_r);
          end else begin
            pend_nxt.all_used = 1'b0;
          end
          state_nxt = S_DONE;
        end else if (scan_r + 1'b1 == count_r) begin
          state_nxt = S_MISS;
        end else begin
          scan_nxt  = scan_r + 1'b1;
          state_nxt = S_RD;
        end
      end

      S_MISS: begin
        // No zero entry below the count.
        if (op_r == hst_pkg::KIND_ADD) begin
          if (int'(count_r) < hst_pkg::DEPTH) begin
            mem_we        = 1'b1;
            mem_waddr     = count_r[hst_pkg::ADDR_W-1:0];
            pend_nxt.slot = hst_pkg::SLOT_W'(count_r);
            count_nxt     = count_r + 1'b1;
          end else begin
            pend_nxt.status = hst_pkg::ST_FULL;
          end
        end else begin
          pend_nxt.all_used = 1'b1;
        end
        state_nxt = S_DONE;
      end

      S_FILL: begin
        if (scan_r[hst_pkg::ADDR_W-1:0] == uidx_r) begin
          mem_we    = 1'b1;
          mem_waddr = uidx_r;
          count_nxt = scan_r + 1'b1;
          state_nxt = S_DONE;
        end else begin
          vld_clr  = 1'b1;
          scan_nxt = scan_r + 1'b1;
        end
      end

      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Sequencer state, count, valid bits and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      scan_r      <= '0;
      op_r        <= hst_pkg::KIND_ADD;
      floor_r     <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      scan_r  <= scan_nxt;
      op_r    <= op_nxt;
      if (cfg_we) begin
        floor_r <= cfg_wdata;
      end
      if (mem_we) begin
        valid_r[mem_waddr] <= 1'b1;
      end
      if (vld_clr) begin
        valid_r[vld_clr_addr] <= 1'b0;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    uidx_r <= uidx_nxt;
    pend_r <= pend_nxt;
    if (state_r == S_DONE && out_free) begin
      out_res_r <= pend_r;
    end
  end

  // Entry memory.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[scan_r[hst_pkg::ADDR_W-1:0]];
    rvld_r  <= valid_r[scan_r[hst_pkg::ADDR_W-1:0]];
  end

  // Count never runs past the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= hst_pkg::DEPTH)
    else $error("used count exceeds table depth");

  // A scan only runs inside a non-empty table and below the count.
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD || state_r == S_CK) |-> (count_r != '0 && scan_r < count_r))
    else $error("scan pointer outside used range");

  // One operation at a time: after a transfer in, ready drops.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("ready held after accepted transfer");

  // Clear-all empties the table at once.
  a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.kind == hst_pkg::KIND_CLEAR_ALL)
      |=> (count_r == '0))
    else $error("clear-all left a non-zero count");

endmodule
